// ----- hw/rtl/ranked_max_priority_queue_defines.svh -----
// Assertion macros shared by the priority queue modules.
`ifndef RANKED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define RANKED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define RMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/rmpq_pkg.sv -----
package rmpq_pkg;
    localparam int Capacity   = 16;
    localparam int ValueWidth = 32;
    localparam int IdxW       = $clog2(Capacity);
    localparam int CntW       = $clog2(Capacity + 1);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_PEEK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RANK  = 2'd3
    } t_err;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] value;
        logic [3:0]  rank;
    } t_req;

    typedef struct packed {
        logic [31:0] result_value;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic [1:0]  error_code;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic execute;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
    } t_status;
endpackage

// ----- hw/rtl/rmpq_if.sv -----
interface rmpq_req_if;
    import rmpq_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rmpq_rsp_if;
    import rmpq_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/rmpq_datapath.sv -----
`include "ranked_max_priority_queue_defines.svh"

module rmpq_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rmpq_pkg::t_cmd   i_cmd,
    input  rmpq_pkg::t_req   i_req,
    output rmpq_pkg::t_rsp   o_rsp,
    output rmpq_pkg::t_status o_status
);
    import rmpq_pkg::*;

    // Sorted cell chain, largest value in cell 0.
    logic [ValueWidth-1:0] r_cell [Capacity];
    logic [CntW-1:0]       r_count;
    t_req                  r_req;
    t_rsp                  r_rsp;
    logic                  r_done;

    logic [ValueWidth-1:0] n_cell [Capacity];
    logic [CntW-1:0]       n_count;
    t_rsp                  n_rsp;
    logic [ValueWidth-1:0] w_val;
    logic [Capacity-1:0]   w_ge;
    logic [Capacity-1:0]   w_live;
    logic                  w_rank_ok;
    logic [IdxW-1:0]       w_rank;
    logic [IdxW-1:0]       w_del;
    t_op                   w_op;

    assign w_val  = r_req.value[ValueWidth-1:0];
    assign w_op   = t_op'(r_req.operation);
    assign w_rank = IdxW'(r_req.rank);
    assign w_rank_ok = CntW'(r_req.rank) < r_count;

    // Each live cell compares its value with the pushed one.
    always_comb begin
        for (int i = 0; i < Capacity; i++) begin
            w_live[i] = CntW'(i) < r_count;
            w_ge[i]   = w_live[i] && (r_cell[i] >= w_val);
        end
    end

    // Next state of every cell, chosen per cell from its neighbors.
    always_comb begin
        t_err err;
        logic peek;
        err = ERR_OK;
        peek = 1'b0;
        w_del = '0;
        n_count = r_count;
        for (int i = 0; i < Capacity; i++) begin
            n_cell[i] = r_cell[i];
        end
        unique case (w_op)
            OP_PUSH: begin
                if (r_count == CntW'(Capacity)) begin
                    err = ERR_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < Capacity; i++) begin
                        if (!w_ge[i]) begin
                            if (i == 0 || w_ge[(i == 0) ? 0 : i-1]) begin
                                n_cell[i] = w_val;
                            end else begin
                                n_cell[i] = r_cell[(i == 0) ? 0 : i-1];
                            end
                        end
                    end
                end
            end
            OP_POP, OP_REMOVE: begin
                if (w_op == OP_POP) begin
                    w_del = '0;
                    if (r_count == '0) err = ERR_EMPTY;
                end else begin
                    w_del = w_rank;
                    if (!w_rank_ok) err = ERR_RANK;
                end
                if (err == ERR_OK) begin
                    n_count = r_count - 1'b1;
                    for (int i = 0; i < Capacity - 1; i++) begin
                        if (IdxW'(i) >= w_del) n_cell[i] = r_cell[i+1];
                    end
                end
            end
            OP_PEEK: begin
                if (!w_rank_ok) err = ERR_RANK;
                else peek = 1'b1;
            end
            default: err = ERR_OK;
        endcase
        n_rsp.error_code  = err;
        n_rsp.entry_count = 5'(n_count);
        n_rsp.is_empty    = (n_count == '0);
        if (peek) begin
            n_rsp.result_value = 32'(r_cell[w_rank]);
        end else if (n_count == '0) begin
            n_rsp.result_value = '0;
        end else begin
            n_rsp.result_value = 32'(n_cell[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < Capacity; i++) r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) r_count <= n_count;
        end
    end

    assign o_rsp = r_rsp;
    assign o_status.done = r_done;

    `RMPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(Capacity))
    `RMPQ_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.execute, (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1))
    `RMPQ_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_cmd.execute, $stable(r_count))
endmodule

// ----- hw/rtl/rmpq_ctrl.sv -----
`include "ranked_max_priority_queue_defines.svh"

module rmpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rmpq_pkg::t_cmd    o_cmd,
    input  rmpq_pkg::t_status i_status
);
    import rmpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Accept, update the cell chain, then hold the result until taken.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_SEND;
            S_SEND: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_SEND);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

    `RMPQ_ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `RMPQ_ASSERT_IMPL(a_done_send, i_clk, i_rst_n, i_status.done, r_state == S_SEND)
    `RMPQ_ASSERT_NEXT(a_exec_once, i_clk, i_rst_n, o_cmd.execute, !o_cmd.execute)
endmodule

// ----- hw/rtl/ranked_max_priority_queue.sv -----
// Bounded max-priority queue of 16 unsigned 32-bit values kept sorted in a
// chain of compare-and-shift cells. Each request transfer (push, pop, remove
// at rank, peek at rank) yields one response transfer. A request is captured
// in the idle state, the cell chain updates in the execute state, and the send
// state holds the response until taken; only then is a new request accepted.
module ranked_max_priority_queue (
    input logic i_clk,
    input logic i_rst_n,
    rmpq_req_if.sink   req,
    rmpq_rsp_if.source rsp
);
    import rmpq_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rmpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req.valid),
        .o_in_ready (req.ready),
        .o_out_valid(rsp.valid),
        .i_out_ready(rsp.ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    rmpq_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (req.payload),
        .o_rsp   (rsp.payload),
        .o_status(w_status)
    );
endmodule

// ----- tb/tb_ranked_max_priority_queue.sv -----
module tb_ranked_max_priority_queue;
    import rmpq_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic i_clk;
    logic i_rst_n;

    rmpq_req_if req_ch ();
    rmpq_rsp_if rsp_ch ();

    ranked_max_priority_queue u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (req_ch.sink),
        .rsp    (rsp_ch.source)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Shadow copy of the sorted store.
    logic [31:0] shadow_entries[Capacity];
    int          shadow_count;

    t_req pending_reqs[$];
    t_rsp queue_results[$];
    int   fail_count;
    int   results_seen;
    bit   stim_done;
    bit   hold_off;
    bit   req_taken;

    // Applies one request to the shadow store and returns the expected response.
    function automatic t_rsp apply_queue_op(t_req r);
        t_rsp rs;
        t_err err;
        bit   peeked;
        int   pos;
        err = ERR_OK;
        peeked = 1'b0;
        case (t_op'(r.operation))
            OP_PUSH: begin
                if (shadow_count >= Capacity) begin
                    err = ERR_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_entries[pos] >= r.value) pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = r.value;
                    shadow_count++;
                end
            end
            OP_POP, OP_REMOVE: begin
                pos = (t_op'(r.operation) == OP_POP) ? 0 : int'(r.rank);
                if (shadow_count == 0 && t_op'(r.operation) == OP_POP) begin
                    err = ERR_EMPTY;
                end else if (pos >= shadow_count) begin
                    err = ERR_RANK;
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            default: begin
                if (int'(r.rank) >= shadow_count) err = ERR_RANK;
                else peeked = 1'b1;
            end
        endcase
        rs.result_value = peeked ? shadow_entries[r.rank]
                        : (shadow_count > 0 ? shadow_entries[0] : 32'd0);
        rs.entry_count  = 5'(shadow_count);
        rs.is_empty     = (shadow_count == 0);
        rs.error_code   = err;
        return rs;
    endfunction

    function automatic t_req make_req(t_op op, logic [31:0] v, logic [3:0] rk);
        t_req r;
        r.operation = op;
        r.value     = v;
        r.rank      = rk;
        return r;
    endfunction

    // Appends one item to the list of pending requests.
    task automatic add_req(t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    // Random values: often clustered to create duplicates, sometimes extremes.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Stimulus: directed items first, then random phases biased toward fill or drain.
    initial begin
        int fill_bias;
        for (int i = 0; i < 17; i++)
            add_req(make_req(OP_PUSH, (i == 0) ? 32'd0 :
                (i == 1) ? 32'hFFFF_FFFF : (i == 2) ? 32'd5 : 32'(i * 3), 4'(i)));
        add_req(make_req(OP_PEEK, 32'hFFFF_FFFF, 4'd15));
        add_req(make_req(OP_PEEK, 32'd0, 4'd0));
        add_req(make_req(OP_REMOVE, 32'd0, 4'd15));
        add_req(make_req(OP_REMOVE, 32'd0, 4'd15));
        add_req(make_req(OP_PEEK, 32'd0, 4'd15));
        add_req(make_req(OP_POP, 32'd0, 4'd0));
        for (int i = 0; i < 14; i++)
            add_req(make_req(OP_POP, 32'hA5A5_A5A5, 4'hF));
        add_req(make_req(OP_POP, 32'd0, 4'd0));
        add_req(make_req(OP_REMOVE, 32'd0, 4'd0));
        add_req(make_req(OP_PEEK, 32'd0, 4'd0));
        for (int p = 0; p < 20; p++) begin
            fill_bias = (p % 2 == 0) ? 75 : 25;
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 99) < fill_bias)
                    add_req(make_req(OP_PUSH, rand_value(), 4'($urandom)));
                else
                    add_req(make_req(t_op'($urandom_range(1, 3)),
                        $urandom, 4'($urandom)));
            end
        end
    end

    // Reset.
    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Driver: bursts of offers separated by random gaps.
    int burst_left;
    int gap_left;
    initial begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        burst_left     = 0;
        gap_left       = 0;
        req_taken      = 1'b0;
        stim_done      = 1'b0;
    end

    // Remember whether the offered request was transferred at the rising edge.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                // Transferred at the last rising edge: move on to the next item.
                void'(pending_reqs.pop_front());
            end
            if (req_ch.valid && !req_taken) begin
                // Keep offering the same item.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= pending_reqs[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_ch.valid <= 1'b0;
                stim_done    <= 1'b1;
            end
        end
    end

    // Receiver ready pattern, with one long hold-off while the sender keeps offering.
    int rx_cycle;
    initial begin
        rsp_ch.ready = 1'b0;
        rx_cycle     = 0;
        hold_off     = 1'b0;
    end

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        hold_off <= (rx_cycle >= 400 && rx_cycle < 700);
        if (!i_rst_n || hold_off)
            rsp_ch.ready <= 1'b0;
        else if ((rx_cycle / 64) % 3 == 0)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: predict on each request transfer, and compare each response
    // transfer with the oldest expectation.
    t_rsp exp_rsp;
    t_rsp got_rsp;
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready)
            queue_results = {queue_results, apply_queue_op(req_ch.payload)};
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got_rsp = rsp_ch.payload;
            results_seen++;
            if (queue_results.size() == 0) begin
                $error("unexpected response transfer");
                fail_count++;
            end else begin
                exp_rsp = queue_results.pop_front();
                if (got_rsp.result_value !== exp_rsp.result_value) begin
                    $error("result_value expected %h actual %h",
                        exp_rsp.result_value, got_rsp.result_value);
                    fail_count++;
                end
                if (got_rsp.entry_count !== exp_rsp.entry_count) begin
                    $error("entry_count expected %0d actual %0d",
                        exp_rsp.entry_count, got_rsp.entry_count);
                    fail_count++;
                end
                if (got_rsp.is_empty !== exp_rsp.is_empty) begin
                    $error("is_empty expected %b actual %b",
                        exp_rsp.is_empty, got_rsp.is_empty);
                    fail_count++;
                end
                if (got_rsp.error_code !== exp_rsp.error_code) begin
                    $error("error_code expected %0d actual %0d",
                        exp_rsp.error_code, got_rsp.error_code);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer, and end of run.
    int idle_cycles;
    initial begin
        fail_count   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("simulation failed");
                $finish;
            end
            if (stim_done && queue_results.size() == 0) begin
                repeat (10) @(posedge i_clk);
                $display("Checked %0d responses across push, pop, remove and peek,",
                    results_seen);
                $display("including full, empty and out-of-range rank errors.");
                if (fail_count == 0 && queue_results.size() == 0)
                    $display("simulation ok");
                else
                    $display("simulation failed");
                $finish;
            end
        end
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rmpq_pkg.sv
hw/rtl/rmpq_if.sv
hw/rtl/rmpq_datapath.sv
hw/rtl/rmpq_ctrl.sv
hw/rtl/ranked_max_priority_queue.sv
tb/tb_ranked_max_priority_queue.sv
